// File: rtl/core/babre_pkg.sv
// babre_pkg: shared constants and types for the bitmap run encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package babre_pkg;

    localparam int GROUP_W = 7;
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 6;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [GROUP_W-1:0] GROUP_MASK     = 7'h7F;
    localparam logic [CODE_W-1:0]  LITERAL_FLAG   = 8'h80;
    localparam logic [CODE_W-1:0]  ONE_FILL_FLAG  = 8'h40;
    localparam logic [CODE_W-1:0]  KIND_MASK      = 8'hC0;
    localparam logic [CODE_W-1:0]  FILL_COUNT_ONE = 8'h01;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 6'h3F;

    // number of code beats pushed by one group
    typedef enum logic [1:0] {
        PUSH_NONE = 2'd0,
        PUSH_ONE  = 2'd1,
        PUSH_TWO  = 2'd2
    } push_cnt_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_byte;
        logic              last_code;
    } code_beat_t;

    typedef struct packed {
        push_cnt_t  cnt;
        code_beat_t first;
        code_beat_t second;
    } push_t;

endpackage

// File: rtl/core/babre_if.sv
// babre_in_if / babre_out_if: valid/ready channels of the bitmap run encoder
// depends on babre_pkg for field widths
`timescale 1ns / 1ps

interface babre_in_if;
    logic                          valid;
    logic                          ready;
    logic [babre_pkg::GROUP_W-1:0] group_bits;
    logic                          last_group;

    modport source (output valid, output group_bits, output last_group, input ready);
    modport sink (input valid, input group_bits, input last_group, output ready);
endinterface

interface babre_out_if;
    logic                         valid;
    logic                         ready;
    logic [babre_pkg::CODE_W-1:0] code_byte;
    logic                         last_code;

    modport source (output valid, output code_byte, output last_code, input ready);
    modport sink (input valid, input code_byte, input last_code, output ready);
endinterface

// File: rtl/core/babre_encoder.sv
// babre_encoder: input register, group classification and held-code merge
// depends on babre_pkg; feeds up to two code beats per group to babre_fifo
`timescale 1ns / 1ps

module babre_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [babre_pkg::GROUP_W-1:0] group_bits,
    input  logic                          last_group,
    input  logic                          space_ok,
    output babre_pkg::push_t              push
);
    import babre_pkg::*;

    logic               stage_valid_reg, stage_valid_next;
    logic [GROUP_W-1:0] bits_reg, bits_next;
    logic               last_reg, last_next;
    logic [CODE_W-1:0]  held_code_reg, held_code_next;
    logic               held_valid_reg, held_valid_next;

    logic              advance;
    logic              is_zero;
    logic              is_ones;
    logic              is_fill;
    logic [CODE_W-1:0] kind;
    logic              merged;
    logic              emit_held;
    logic [CODE_W-1:0] fresh_code;
    logic [CODE_W-1:0] new_code;

    assign advance  = stage_valid_reg && space_ok;
    assign in_ready = !stage_valid_reg || space_ok;

    // input register
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        bits_next        = bits_reg;
        last_next        = last_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
            bits_next        = group_bits;
            last_next        = last_group;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // classify and merge
    assign is_zero    = (bits_reg == '0);
    assign is_ones    = (bits_reg == GROUP_MASK);
    assign is_fill    = is_zero || is_ones;
    assign kind       = is_ones ? ONE_FILL_FLAG : '0;
    assign merged     = is_fill && held_valid_reg && ((held_code_reg & KIND_MASK) == kind)
                        && (held_code_reg[COUNT_W-1:0] != COUNT_MAX);
    assign fresh_code = is_fill ? (kind | FILL_COUNT_ONE) : (LITERAL_FLAG | {1'b0, bits_reg});
    assign new_code   = merged ? (held_code_reg + FILL_COUNT_ONE) : fresh_code;
    assign emit_held  = !merged && held_valid_reg;

    always_comb
    begin
        push.cnt              = PUSH_NONE;
        push.first.code_byte  = held_code_reg;
        push.first.last_code  = 1'b0;
        push.second.code_byte = new_code;
        push.second.last_code = 1'b1;
        held_code_next        = held_code_reg;
        held_valid_next       = held_valid_reg;
        if (advance)
        begin
            if (emit_held)
            begin
                push.cnt = last_reg ? PUSH_TWO : PUSH_ONE;
            end
            else if (last_reg)
            begin
                push.cnt             = PUSH_ONE;
                push.first.code_byte = new_code;
                push.first.last_code = 1'b1;
            end
            if (last_reg)
            begin
                held_code_next  = '0;
                held_valid_next = 1'b0;
            end
            else
            begin
                held_code_next  = new_code;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            held_code_reg   <= '0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            held_code_reg   <= held_code_next;
            held_valid_reg  <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        last_reg <= last_next;
    end

endmodule

// File: rtl/core/babre_fifo.sv
// babre_fifo: small result queue, up to two writes and one read per cycle
// depends on babre_pkg for the beat and push types
`timescale 1ns / 1ps

module babre_fifo #(
    parameter int DEPTH = babre_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  babre_pkg::push_t      push,
    output logic                  space_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output babre_pkg::code_beat_t out_beat
);
    import babre_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] SPACE_LIMIT = CW'(DEPTH - 2);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        ptr_inc = (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
    endfunction

    code_beat_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_ptr_plus1;
    logic          pop;

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign out_valid    = (count_reg != '0);
    assign out_beat     = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign space_ok     = (count_reg <= SPACE_LIMIT);

    always_comb
    begin
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.cnt)
            PUSH_ONE: wr_ptr_next = wr_ptr_plus1;
            PUSH_TWO: wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default:  wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt == PUSH_ONE || push.cnt == PUSH_TWO)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == PUSH_TWO)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// File: rtl/core/byte_aligned_bitmap_run_encoder.sv
// byte_aligned_bitmap_run_encoder: top level of the bitmap run encoder
// depends on babre_pkg, babre_if, babre_encoder and babre_fifo
//
// usage
//   in_ch carries one 7-bit bitmap group per beat (bit 0 earliest) and a
//   last_group flag that closes the stream. out_ch carries code bytes:
//   literal (bit 7 set), zero fill or one fill (bit 6) with a 6-bit count.
//   fills of the same kind merge into the held code up to a count of 63.
//   the held code leaves when a different code follows or its count is full,
//   or on last_group, where the stream's last byte carries last_code and the
//   next beat opens a new stream. a released byte passes the input register,
//   then the result queue, before it is valid on out_ch.
//   throughput: one group per cycle; a group emits at most two bytes, but a
//   stream never emits more bytes than it has groups, so with out_ch ready
//   the queue never fills and in_ch never stalls.
//   stall: while out_ch is not ready, bytes wait in the queue; in_ch drops
//   ready once the input register holds a group and fewer than two queue
//   entries are free.
//   reset: rst_n clears the queue, the input register and the held code.
`timescale 1ns / 1ps

module byte_aligned_bitmap_run_encoder #(
    parameter int FIFO_DEPTH = babre_pkg::FIFO_DEPTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    babre_in_if.sink    in_ch,
    babre_out_if.source out_ch
);
    import babre_pkg::*;

    push_t      push;
    logic       space_ok;
    code_beat_t out_beat;

    babre_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .group_bits (in_ch.group_bits),
        .last_group (in_ch.last_group),
        .space_ok   (space_ok),
        .push       (push)
    );

    babre_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_beat  (out_beat)
    );

    assign out_ch.code_byte = out_beat.code_byte;
    assign out_ch.last_code = out_beat.last_code;

endmodule

// File: rtl/core/babre_checker.sv
// babre_checker: port-level assertions for the bitmap run encoder
// depends on babre_pkg; bound to byte_aligned_bitmap_run_encoder below
`timescale 1ns / 1ps

module babre_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [babre_pkg::CODE_W-1:0] code_byte,
    input logic                         last_code
);
    import babre_pkg::*;

    logic              prev_open_fill_reg, prev_open_fill_next;
    logic [CODE_W-1:0] prev_kind_reg, prev_kind_next;
    logic              is_fill;

    assign is_fill = !code_byte[CODE_W-1];

    // last sent byte was a fill that still had room and did not end the stream
    always_comb
    begin
        prev_open_fill_next = prev_open_fill_reg;
        prev_kind_next      = prev_kind_reg;
        if (out_valid && out_ready)
        begin
            prev_open_fill_next = is_fill && !last_code
                                  && (code_byte[COUNT_W-1:0] != COUNT_MAX);
            prev_kind_next      = code_byte & KIND_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_open_fill_reg <= 1'b0;
            prev_kind_reg      <= '0;
        end
        else
        begin
            prev_open_fill_reg <= prev_open_fill_next;
            prev_kind_reg      <= prev_kind_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(last_code))
        else $error("output beat changed while stalled");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_fill |-> code_byte[COUNT_W-1:0] != '0)
        else $error("fill code with zero count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output pending");

    a_merge_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prev_open_fill_reg && is_fill
        |-> (code_byte & KIND_MASK) != prev_kind_reg)
        else $error("mergeable fills sent as separate bytes");

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !out_valid |=> in_ready || out_valid)
        else $error("input blocked while idle");

endmodule

bind byte_aligned_bitmap_run_encoder babre_checker u_babre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .code_byte (out_ch.code_byte),
    .last_code (out_ch.last_code)
);
